>>> sv/bsa_pkg.sv
// Package for the banker's safety allocator: sizes, codes, channel structs,
// controller states and the entry layout of the held/max table.
// No dependencies.
package bsa_pkg;

  localparam int unsigned NUM_PROC = 16;
  localparam int unsigned NUM_RES  = 16;
  localparam int unsigned AMT_W    = 16;
  localparam int unsigned PID_W    = $clog2(NUM_PROC);
  localparam int unsigned RID_W    = $clog2(NUM_RES);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ADDR_W   = PID_W + RID_W;
  localparam int unsigned DEPTH    = NUM_PROC * NUM_RES;

  typedef logic [AMT_W-1:0] amt_t;

  typedef enum logic [1:0] {
    ACT_LOAD_AVAIL = 2'd0,
    ACT_LOAD_ENTRY = 2'd1,
    ACT_REQUEST    = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_NEED    = 3'd1,
    STAT_AVAIL   = 3'd2,
    STAT_UNSAFE  = 3'd3,
    STAT_PENDING = 3'd4
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_PROCESS_COUNT  = 2'd0;
  localparam logic [1:0] CFG_RESOURCE_COUNT = 2'd1;
  localparam logic [1:0] CFG_SAFETY_ENABLE  = 2'd2;

  typedef struct packed {
    action_e          action;
    logic [PID_W-1:0] process_id;
    logic [RID_W-1:0] resource_id;
    amt_t             amount;
    amt_t             claim_limit;
    logic             last;
  } in_t;

  typedef struct packed {
    status_e status;
    logic    granted;
    logic    all_finished;
  } out_t;

  // clamped configuration as seen by the controller
  typedef struct packed {
    logic [CNT_W-1:0] procs;
    logic [CNT_W-1:0] ress;
    logic             safety;
  } cfg_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  typedef struct packed {
    amt_t held;
    amt_t maxc;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_NEED_RD,
    S_NEED_EV,
    S_AVAIL,
    S_WALK_INIT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_REL_RD,
    S_REL_EV,
    S_PASS_END,
    S_COMMIT_RD,
    S_COMMIT_EV,
    S_FINISH
  } state_e;

endpackage

>>> sv/bsa_ram.sv
// Held/max-claim table: single-port synchronous RAM, one process row per
// resource column entry, registered read data. Uses bsa_pkg.
module bsa_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [bsa_pkg::ADDR_W-1:0] addr_i,
  input  bsa_pkg::ent_t              wdata_i,
  output bsa_pkg::ent_t              rdata_o
);

  bsa_pkg::ent_t mem [bsa_pkg::DEPTH];
  bsa_pkg::ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bsa_ctrl.sv
// Request sequencer: loads, need/available checks, safety walk over the
// held/max table and commit. Uses bsa_pkg and bsa_ram.
module bsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsa_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsa_pkg::in_t  in_data_i,
  output bsa_pkg::res_t res_o,
  input  logic          res_take_i
);

  localparam int unsigned NP = bsa_pkg::NUM_PROC;
  localparam int unsigned NR = bsa_pkg::NUM_RES;
  localparam int unsigned W  = bsa_pkg::AMT_W;

  bsa_pkg::state_e state_q, state_d;
  logic [bsa_pkg::ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  bsa_pkg::amt_t avail_q [NR];
  bsa_pkg::amt_t avail_d [NR];
  bsa_pkg::amt_t req_q [NR];
  bsa_pkg::amt_t req_d [NR];
  bsa_pkg::amt_t work_q [NR];
  bsa_pkg::amt_t work_d [NR];
  logic [NP-1:0] fin_q, fin_d;
  logic [NP-1:0] tfin_q, tfin_d;
  logic dec_q, dec_d;
  logic found_q, found_d;
  logic [bsa_pkg::PID_W-1:0] i_q, i_d;
  logic [bsa_pkg::RID_W-1:0] j_q, j_d;
  logic [bsa_pkg::PID_W-1:0] p_q, p_d;
  bsa_pkg::status_e status_q, status_d;
  logic grant_q, grant_d;
  logic reached_q, reached_d;

  logic in_acc;
  logic [NP-1:0] proc_mask;
  logic [NR-1:0] res_mask;
  logic i_last, j_last, all_tfin, all_fin;
  logic need_fail, avail_fail, scan_fail;
  logic ram_we;
  logic [bsa_pkg::ADDR_W-1:0] ram_addr;
  bsa_pkg::ent_t ram_wdata, ent;
  bsa_pkg::amt_t rq, hn, a1, rel;
  logic [W:0] th, nd;
  logic [W+1:0] ns;
  logic reached;

  function automatic bsa_pkg::amt_t sat_add(input bsa_pkg::amt_t a, input bsa_pkg::amt_t b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? '1 : s[W-1:0];
  endfunction

  bsa_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ent)
  );

  assign in_stall_o = (state_q != bsa_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      proc_mask[k] = bsa_pkg::CNT_W'(k) < cfg_i.procs;
    end
    for (int k = 0; k < NR; k++) begin
      res_mask[k] = bsa_pkg::CNT_W'(k) < cfg_i.ress;
    end
  end

  assign i_last   = ({1'b0, i_q} == cfg_i.procs - bsa_pkg::CNT_W'(1));
  assign j_last   = ({1'b0, j_q} == cfg_i.ress - bsa_pkg::CNT_W'(1));
  assign all_tfin = &(tfin_q | ~proc_mask);
  assign all_fin  = &(fin_q | ~proc_mask);

  // need = max - held, signed
  assign nd        = {1'b0, ent.maxc} - {1'b0, ent.held};
  assign need_fail = $signed({1'b0, req_q[j_q]}) > $signed(nd);

  always_comb begin
    avail_fail = 1'b0;
    for (int k = 0; k < NR; k++) begin
      avail_fail = avail_fail | (res_mask[k] && (req_q[k] > avail_q[k]));
    end
  end

  // trial held includes the request for the requesting process
  assign rq        = (i_q == p_q) ? req_q[j_q] : '0;
  assign th        = {1'b0, ent.held} + {1'b0, rq};
  assign ns        = {2'b00, ent.maxc} - {1'b0, th};
  assign scan_fail = $signed(ns) > $signed({2'b00, work_q[j_q]});
  assign rel       = th[W] ? '1 : th[W-1:0];

  // commit; held + request never exceeds the claim once need passed
  assign hn      = ent.held + req_q[j_q];
  assign a1      = avail_q[j_q] - req_q[j_q];
  assign reached = (hn >= ent.maxc);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsa_pkg::S_CLEAR: begin
        if (clr_cnt_q == '1) state_d = bsa_pkg::S_IDLE;
      end
      bsa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == bsa_pkg::ACT_REQUEST && in_data_i.last &&
              ({1'b0, in_data_i.process_id} < cfg_i.procs)) begin
            state_d = bsa_pkg::S_NEED_RD;
          end else begin
            state_d = bsa_pkg::S_FINISH;
          end
        end
      end
      bsa_pkg::S_NEED_RD: state_d = bsa_pkg::S_NEED_EV;
      bsa_pkg::S_NEED_EV: begin
        if (need_fail) state_d = bsa_pkg::S_FINISH;
        else if (j_last) state_d = bsa_pkg::S_AVAIL;
        else state_d = bsa_pkg::S_NEED_RD;
      end
      bsa_pkg::S_AVAIL: begin
        if (avail_fail) state_d = bsa_pkg::S_FINISH;
        else if (cfg_i.safety) state_d = bsa_pkg::S_WALK_INIT;
        else state_d = bsa_pkg::S_COMMIT_RD;
      end
      bsa_pkg::S_WALK_INIT: state_d = bsa_pkg::S_SCAN_RD;
      bsa_pkg::S_SCAN_RD: begin
        if (tfin_q[i_q]) state_d = i_last ? bsa_pkg::S_PASS_END : bsa_pkg::S_SCAN_RD;
        else state_d = bsa_pkg::S_SCAN_EV;
      end
      bsa_pkg::S_SCAN_EV: begin
        if (scan_fail) state_d = i_last ? bsa_pkg::S_PASS_END : bsa_pkg::S_SCAN_RD;
        else if (j_last) state_d = bsa_pkg::S_REL_RD;
        else state_d = bsa_pkg::S_SCAN_RD;
      end
      bsa_pkg::S_REL_RD: state_d = bsa_pkg::S_REL_EV;
      bsa_pkg::S_REL_EV: state_d = j_last ? bsa_pkg::S_PASS_END : bsa_pkg::S_REL_RD;
      bsa_pkg::S_PASS_END: begin
        if (all_tfin) state_d = bsa_pkg::S_COMMIT_RD;
        else if (found_q) state_d = bsa_pkg::S_SCAN_RD;
        else state_d = bsa_pkg::S_FINISH;
      end
      bsa_pkg::S_COMMIT_RD: state_d = bsa_pkg::S_COMMIT_EV;
      bsa_pkg::S_COMMIT_EV: state_d = j_last ? bsa_pkg::S_FINISH : bsa_pkg::S_COMMIT_RD;
      bsa_pkg::S_FINISH: begin
        if (res_take_i) state_d = bsa_pkg::S_IDLE;
      end
      default: state_d = bsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    avail_d   = avail_q;
    req_d     = req_q;
    work_d    = work_q;
    fin_d     = fin_q;
    tfin_d    = tfin_q;
    dec_d     = dec_q;
    found_d   = found_q;
    i_d       = i_q;
    j_d       = j_q;
    p_d       = p_q;
    status_d  = status_q;
    grant_d   = grant_q;
    reached_d = reached_q;
    ram_we    = 1'b0;
    ram_addr  = {p_q, j_q};
    ram_wdata = '0;
    unique case (state_q)
      bsa_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      bsa_pkg::S_IDLE: begin
        ram_addr       = {in_data_i.process_id, in_data_i.resource_id};
        ram_wdata.held = in_data_i.amount;
        ram_wdata.maxc = in_data_i.claim_limit;
        if (in_acc) begin
          status_d = bsa_pkg::STAT_DONE;
          grant_d  = 1'b0;
          case (in_data_i.action)
            bsa_pkg::ACT_LOAD_AVAIL: avail_d[in_data_i.resource_id] = in_data_i.amount;
            bsa_pkg::ACT_LOAD_ENTRY: ram_we = 1'b1;
            bsa_pkg::ACT_REQUEST: begin
              req_d[in_data_i.resource_id] = in_data_i.amount;
              if (!in_data_i.last) begin
                status_d = bsa_pkg::STAT_PENDING;
              end else begin
                dec_d = 1'b1;
                p_d   = in_data_i.process_id;
                j_d   = '0;
                if ({1'b0, in_data_i.process_id} >= cfg_i.procs) status_d = bsa_pkg::STAT_NEED;
              end
            end
            default: ;
          endcase
        end
      end
      bsa_pkg::S_NEED_RD: ;
      bsa_pkg::S_NEED_EV: begin
        if (need_fail) status_d = bsa_pkg::STAT_NEED;
        j_d = j_last ? '0 : j_q + 1'b1;
      end
      bsa_pkg::S_AVAIL: begin
        if (avail_fail) status_d = bsa_pkg::STAT_AVAIL;
        j_d       = '0;
        reached_d = 1'b1;
      end
      bsa_pkg::S_WALK_INIT: begin
        for (int k = 0; k < NR; k++) begin
          work_d[k] = avail_q[k] - req_q[k];
        end
        tfin_d  = fin_q;
        i_d     = '0;
        j_d     = '0;
        found_d = 1'b0;
      end
      bsa_pkg::S_SCAN_RD: begin
        ram_addr = {i_q, j_q};
        if (tfin_q[i_q]) begin
          i_d = i_q + 1'b1;
          j_d = '0;
        end
      end
      bsa_pkg::S_SCAN_EV: begin
        if (scan_fail) begin
          i_d = i_q + 1'b1;
          j_d = '0;
        end else begin
          j_d = j_last ? '0 : j_q + 1'b1;
        end
      end
      bsa_pkg::S_REL_RD: ram_addr = {i_q, j_q};
      bsa_pkg::S_REL_EV: begin
        work_d[j_q] = sat_add(work_q[j_q], rel);
        if (j_last) begin
          tfin_d[i_q] = 1'b1;
          found_d     = 1'b1;
          j_d         = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      bsa_pkg::S_PASS_END: begin
        if (all_tfin) begin
          j_d       = '0;
          reached_d = 1'b1;
        end else if (found_q) begin
          found_d = 1'b0;
          i_d     = '0;
          j_d     = '0;
        end else begin
          status_d = bsa_pkg::STAT_UNSAFE;
        end
      end
      bsa_pkg::S_COMMIT_RD: ;
      bsa_pkg::S_COMMIT_EV: begin
        ram_we         = 1'b1;
        ram_wdata.maxc = ent.maxc;
        if (reached) begin
          ram_wdata.held = '0;
          avail_d[j_q]   = sat_add(a1, hn);
        end else begin
          ram_wdata.held = hn;
          avail_d[j_q]   = a1;
        end
        reached_d = reached_q & reached;
        if (j_last) begin
          if (cfg_i.safety) fin_d[p_q] = reached_q & reached;
          status_d = bsa_pkg::STAT_DONE;
          grant_d  = 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      bsa_pkg::S_FINISH: begin
        if (res_take_i && dec_q) begin
          for (int k = 0; k < NR; k++) begin
            req_d[k] = '0;
          end
          dec_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid             = (state_q == bsa_pkg::S_FINISH);
  assign res_o.data.status       = status_q;
  assign res_o.data.granted      = grant_q;
  assign res_o.data.all_finished = all_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bsa_pkg::S_CLEAR;
      clr_cnt_q <= '0;
      for (int k = 0; k < NR; k++) begin
        avail_q[k] <= '0;
        req_q[k]   <= '0;
      end
      fin_q   <= '0;
      dec_q   <= 1'b0;
      found_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      avail_q   <= avail_d;
      req_q     <= req_d;
      fin_q     <= fin_d;
      dec_q     <= dec_d;
      found_q   <= found_d;
      i_q       <= i_d;
      j_q       <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    tfin_q    <= tfin_d;
    p_q       <= p_d;
    status_q  <= status_d;
    grant_q   <= grant_d;
    reached_q <= reached_d;
  end

endmodule

>>> sv/bankers_safety_allocator.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  bsa_pkg::in_t
// out       output     out_valid/out_stall bsa_pkg::out_t
// cfg       input      cfg_valid/cfg_ready cfg_index (2b), cfg_data (5b)
//
// Loads and non-final request elements: result via the finish state.
// Decision: need check per resource, available check, then in safety mode a
// setup step and up to n passes over the held/max RAM port, then a commit
// per resource.
// After reset the table RAM is cleared entry by entry with in_stall high.
// Input is stalled while a request is decided; a finished result may sit in
// the output register while the next item is taken.
// Uses bsa_pkg, bsa_ctrl.
module bankers_safety_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bsa_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [4:0]    cfg_data_i
);

  logic [bsa_pkg::CNT_W-1:0] procs_q, ress_q;
  logic safety_q;
  logic out_valid_q;
  bsa_pkg::out_t out_data_q;
  bsa_pkg::cfg_t cfg;
  bsa_pkg::res_t res;
  logic res_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q  <= bsa_pkg::CNT_W'(bsa_pkg::NUM_PROC);
      ress_q   <= bsa_pkg::CNT_W'(bsa_pkg::NUM_RES);
      safety_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bsa_pkg::CFG_PROCESS_COUNT:  procs_q  <= cfg_data_i;
        bsa_pkg::CFG_RESOURCE_COUNT: ress_q   <= cfg_data_i;
        bsa_pkg::CFG_SAFETY_ENABLE:  safety_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp counts into 1..max
  always_comb begin
    cfg.procs = procs_q;
    if (procs_q == '0) cfg.procs = bsa_pkg::CNT_W'(1);
    else if (procs_q > bsa_pkg::CNT_W'(bsa_pkg::NUM_PROC))
      cfg.procs = bsa_pkg::CNT_W'(bsa_pkg::NUM_PROC);
    cfg.ress = ress_q;
    if (ress_q == '0) cfg.ress = bsa_pkg::CNT_W'(1);
    else if (ress_q > bsa_pkg::CNT_W'(bsa_pkg::NUM_RES))
      cfg.ress = bsa_pkg::CNT_W'(bsa_pkg::NUM_RES);
    cfg.safety = safety_q;
  end

  bsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_o      (res),
    .res_take_i (res_take)
  );

  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_data_q <= res.data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/bsa_checker.sv
// Port-level checks for bankers_safety_allocator, bound to the top level.
// Uses bsa_pkg.
module bsa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input bsa_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bsa_pkg::out_t out_data_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.status == bsa_pkg::STAT_DONE)
    else $error("grant with non-done status");

  // loads and non-final elements go via the finish state to an empty slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o &&
    (in_data_i.action != bsa_pkg::ACT_REQUEST || !in_data_i.last)
    |-> ##2 out_valid_o)
    else $error("missing result for load or element");

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (.*);

>>> test/tb.sv
// Testbench for bankers_safety_allocator: random and directed request streams,
// checked against a behavioral allocator model kept inside the bench.
// Depends on bsa_pkg and the bankers_safety_allocator RTL.
`timescale 1ns / 1ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bsa_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bsa_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = bsa_pkg::CFG_PROCESS_COUNT;
  logic [4:0] cfg_data_i = '0;

  bankers_safety_allocator dut (.*);

  always #4 clk_i = ~clk_i;

  // allocator state mirror
  logic [15:0] avail_m[16];
  logic [15:0] held_m[16][16];
  logic [15:0] claim_m[16][16];
  bit fin_m[16];
  logic [15:0] req_buf[16];
  logic [4:0] procs_raw = 5'd16;
  logic [4:0] ress_raw = 5'd16;
  bit safety_on = 1'b1;

  bsa_pkg::out_t pending_outcomes[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic int procs_used();
    if (procs_raw < 1) return 1;
    if (procs_raw > 16) return 16;
    return procs_raw;
  endfunction

  function automatic int ress_used();
    if (ress_raw < 1) return 1;
    if (ress_raw > 16) return 16;
    return ress_raw;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hffff;
    return v[15:0];
  endfunction

  function automatic bit walk_is_safe(int p);
    int n;
    int m;
    int pick;
    bit found;
    bit fits;
    bit all;
    longint work[16];
    longint th[16][16];
    bit tf[16];
    n = procs_used();
    m = ress_used();
    for (int j = 0; j < m; j++) work[j] = longint'(avail_m[j]) - req_buf[j];
    for (int i = 0; i < n; i++) begin
      tf[i] = fin_m[i];
      for (int j = 0; j < m; j++) th[i][j] = held_m[i][j];
    end
    for (int j = 0; j < m; j++) th[p][j] += req_buf[j];
    do begin
      pick = 0;
      found = 1'b0;
      for (int i = 0; i < n && !found; i++) begin
        if (tf[i]) continue;
        fits = 1'b1;
        for (int j = 0; j < m; j++)
          if (longint'(claim_m[i][j]) - th[i][j] > work[j]) begin
            fits = 1'b0;
            break;
          end
        if (fits) begin
          found = 1'b1;
          pick = i;
        end
      end
      if (found) begin
        tf[pick] = 1'b1;
        for (int j = 0; j < m; j++) begin
          work[j] = sat16(work[j] + sat16(th[pick][j]));
          th[pick][j] = 0;
        end
      end
      all = 1'b1;
      for (int i = 0; i < n; i++) if (!tf[i]) all = 1'b0;
      if (all) return 1'b1;
    end while (found);
    return 1'b0;
  endfunction

  function automatic bsa_pkg::status_e decide_request(int p, output bit grant);
    int n;
    int m;
    longint h;
    n = procs_used();
    m = ress_used();
    grant = 1'b0;
    if (p >= n) return bsa_pkg::STAT_NEED;
    for (int j = 0; j < m; j++)
      if (longint'(req_buf[j]) > longint'(claim_m[p][j]) - longint'(held_m[p][j]))
        return bsa_pkg::STAT_NEED;
    for (int j = 0; j < m; j++)
      if (req_buf[j] > avail_m[j]) return bsa_pkg::STAT_AVAIL;
    if (safety_on) begin
      if (!walk_is_safe(p)) return bsa_pkg::STAT_UNSAFE;
      fin_m[p] = 1'b1;
    end
    for (int j = 0; j < m; j++) begin
      h = longint'(held_m[p][j]) + req_buf[j];
      held_m[p][j] = h[15:0];
      avail_m[j] = avail_m[j] - req_buf[j];
      if (safety_on ? (h >= claim_m[p][j]) : (h == claim_m[p][j])) begin
        avail_m[j] = sat16(longint'(avail_m[j]) + held_m[p][j]);
        held_m[p][j] = '0;
      end else if (safety_on) begin
        fin_m[p] = 1'b0;
      end
    end
    grant = 1'b1;
    return bsa_pkg::STAT_DONE;
  endfunction

  function automatic bsa_pkg::out_t predict_outcome(bsa_pkg::in_t it);
    bsa_pkg::out_t o;
    bit grant;
    o = '0;
    o.status = bsa_pkg::STAT_DONE;
    grant = 1'b0;
    case (it.action)
      bsa_pkg::ACT_LOAD_AVAIL: avail_m[it.resource_id] = it.amount;
      bsa_pkg::ACT_LOAD_ENTRY: begin
        held_m[it.process_id][it.resource_id] = it.amount;
        claim_m[it.process_id][it.resource_id] = it.claim_limit;
      end
      bsa_pkg::ACT_REQUEST: begin
        req_buf[it.resource_id] = it.amount;
        if (!it.last) begin
          o.status = bsa_pkg::STAT_PENDING;
        end else begin
          o.status = decide_request(it.process_id, grant);
          for (int j = 0; j < 16; j++) req_buf[j] = '0;
        end
      end
      default: ;
    endcase
    o.granted = grant;
    o.all_finished = 1'b1;
    for (int i = 0; i < procs_used(); i++) if (!fin_m[i]) o.all_finished = 1'b0;
    return o;
  endfunction

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle);

  always @(posedge clk_i) begin
    bsa_pkg::out_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (out_data_o.status !== exp_o.status || out_data_o.granted !== exp_o.granted ||
            out_data_o.all_finished !== exp_o.all_finished) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_o, out_data_o);
        end
      end
    end
  end

  task automatic send_req(input bsa_pkg::in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_stall_o);
    pending_outcomes.push_back(predict_outcome(it));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bsa_pkg::CFG_PROCESS_COUNT: procs_raw = val;
      bsa_pkg::CFG_RESOURCE_COUNT: ress_raw = val;
      bsa_pkg::CFG_SAFETY_ENABLE: safety_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic bsa_pkg::in_t make_item(bsa_pkg::action_e a, int p, int r, int amt,
                                             int lim, bit last);
    bsa_pkg::in_t it;
    it.action = a;
    it.process_id = p[3:0];
    it.resource_id = r[3:0];
    it.amount = amt[15:0];
    it.claim_limit = lim[15:0];
    it.last = last;
    return it;
  endfunction

  task automatic send_noise();
    bsa_pkg::in_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(bsa_pkg::in_t)-1:0];
    send_req(it);
  endtask

  // extremes of fields, each action, negative need, idle process, unsafe and avail failures
  task automatic test_directed();
    send_req(make_item(bsa_pkg::ACT_LOAD_AVAIL, 0, 0, 16'hffff, 0, 0));
    send_req(make_item(bsa_pkg::ACT_LOAD_AVAIL, 15, 15, 0, 16'hffff, 1));
    send_req(make_item(bsa_pkg::ACT_LOAD_ENTRY, 15, 15, 16'hffff, 16'hffff, 0));
    send_req(make_item(bsa_pkg::ACT_LOAD_ENTRY, 3, 0, 5, 2, 0));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 3, 0, 0, 0, 1));
    send_req(make_item(bsa_pkg::ACT_NONE, 15, 15, 16'hffff, 16'hffff, 1));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 0, 0, 1, 0, 0));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 0, 15, 16'hffff, 0, 1));
    write_cfg(bsa_pkg::CFG_PROCESS_COUNT, 5'd2);
    write_cfg(bsa_pkg::CFG_RESOURCE_COUNT, 5'd1);
    send_req(make_item(bsa_pkg::ACT_REQUEST, 9, 0, 0, 0, 1));
    send_req(make_item(bsa_pkg::ACT_LOAD_AVAIL, 0, 0, 3, 0, 0));
    send_req(make_item(bsa_pkg::ACT_LOAD_ENTRY, 0, 0, 0, 4, 0));
    send_req(make_item(bsa_pkg::ACT_LOAD_ENTRY, 1, 0, 1, 6, 0));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 0, 0, 4, 0, 1));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 1, 0, 3, 0, 1));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 0, 0, 3, 0, 1));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 0, 0, 1, 0, 1));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 1, 0, 5, 0, 1));
    write_cfg(bsa_pkg::CFG_SAFETY_ENABLE, 5'd0);
    send_req(make_item(bsa_pkg::ACT_LOAD_ENTRY, 0, 0, 0, 4, 0));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 0, 0, 4, 0, 1));
    send_req(make_item(bsa_pkg::ACT_REQUEST, 1, 0, 2, 0, 1));
  endtask

  task automatic run_scenario(input logic [4:0] np, input logic [4:0] nr, input bit safe,
                              input int budget);
    int n;
    int m;
    int sent;
    int p;
    int lim;
    write_cfg(bsa_pkg::CFG_PROCESS_COUNT, np);
    write_cfg(bsa_pkg::CFG_RESOURCE_COUNT, nr);
    write_cfg(bsa_pkg::CFG_SAFETY_ENABLE, {4'd0, safe});
    n = procs_used();
    m = ress_used();
    sent = 0;
    for (int j = 0; j < m; j++)
      send_req(make_item(bsa_pkg::ACT_LOAD_AVAIL, 0, j, $urandom_range(12), 0, 0));
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++) begin
        lim = $urandom_range(8);
        send_req(make_item(bsa_pkg::ACT_LOAD_ENTRY, i, j,
                           ($urandom_range(19) == 0) ? lim + 1 : $urandom_range(lim), lim, 0));
      end
    while (sent < budget) begin
      if ($urandom_range(9) == 0) begin
        send_noise();
        sent++;
      end else begin
        p = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
        for (int j = 0; j < m; j++) begin
          send_req(make_item(bsa_pkg::ACT_REQUEST, p, j, $urandom_range(3), $urandom,
                             j == m - 1));
          sent++;
        end
      end
      // hold off until the block has answered everything
      if ($urandom_range(29) == 0) drain();
    end
  endtask

  task automatic test_random_phase(input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    run_scenario(5'd4, 5'd3, 1'b1, 20);
    run_scenario(5'd3, 5'd2, 1'b0, 14);
    run_scenario(5'd0, 5'd31, 1'b1, 1);
    run_scenario(5'd31, 5'd0, 1'b1, 4);
  endtask

  initial begin
    for (int j = 0; j < 16; j++) begin
      avail_m[j] = '0;
      req_buf[j] = '0;
      fin_m[j] = 1'b0;
      for (int k = 0; k < 16; k++) begin
        held_m[j][k] = '0;
        claim_m[j][k] = '0;
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phase(25, 69);
    test_random_phase(69, 25);
    test_random_phase(0, 0);
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
